>>> hw/rtl/l4co_pkg.sv
// ----------------------------------------------------------------------------
// l4co_pkg: shared types and constants
// Frame summary record passed from the byte front end to the checksum back
// end, status codes, protocol numbers and register indexes.
// ----------------------------------------------------------------------------
package l4co_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 16384;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Wide enough for any frame length up to 65536 bytes.
  localparam int LEN_W = 17;

  localparam logic [13:0] MTU_RESET  = 14'd1500;
  localparam logic        IPV6_RESET = 1'b1;

  // Register indexes.
  localparam logic REG_MTU  = 1'b0;
  localparam logic REG_IPV6 = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISMATCH  = 3'd1;
  localparam logic [2:0] ST_GEN       = 3'd2;
  localparam logic [2:0] ST_BADLEN    = 3'd3;
  localparam logic [2:0] ST_UNHANDLED = 3'd4;

  // IP protocol numbers.
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_IGMP  = 8'd2;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;

  localparam logic [7:0] ICMP6_ECHO_REQ = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REP = 8'd129;

  localparam logic [7:0] ETYPE_V6_HI = 8'h86;
  localparam logic [7:0] ETYPE_V6_LO = 8'hDD;
  localparam logic [3:0] IHL_MASK    = 4'h0F;

  // Everything the back end needs about one finished frame.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             is6;
    logic [3:0]       hw;
    logic [15:0]      plen;
    logic [7:0]       proto;
    logic [7:0]       icmp6;
    logic [15:0]      rc0;
    logic [15:0]      rc1;
    logic [15:0]      rc2;
    logic [31:0]      asum;
    logic [31:0]      psum;
    logic             dir;
  } frame_sum_t;

endpackage

>>> hw/rtl/l4co_if.sv
// ----------------------------------------------------------------------------
// l4co_if: channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface l4co_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       outgoing;

  modport source (output valid, data_byte, last_byte, outgoing, input ready);
  modport sink   (input valid, data_byte, last_byte, outgoing, output ready);
endinterface

interface l4co_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] checksum_value;
  logic [13:0] checksum_offset;

  modport source (output valid, status, checksum_value, checksum_offset, input ready);
  modport sink   (input valid, status, checksum_value, checksum_offset, output ready);
endinterface

>>> hw/rtl/l4_checksum_offload.sv
// ----------------------------------------------------------------------------
// l4_checksum_offload: layer-4 checksum check and generation
// Sums TCP, UDP, ICMP, IGMP and ICMPv6 checksums over Ethernet frames fed one
// byte per word, and returns one result word per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while the summary queue has room,
// including one-byte frames. A frame's summary goes through the queue write,
// the check stage, the fold stage and the output register.
// The front end stalls only when the summary queue (QUEUE_DEPTH frames) is full.
// Reset (synchronous, active high) clears all frame state and the queue and
// sets mtu_bytes to 1500 and ipv6_enable to 1.
module l4_checksum_offload
  import l4co_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  l4co_in_if.sink     frame,
  l4co_out_if.source  result
);

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce this. Both halves read them directly.
  logic [13:0] mtu_bytes;
  logic        ipv6_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu_bytes   <= MTU_RESET;
      ipv6_enable <= IPV6_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MTU:  mtu_bytes   <= cfg_data;
        REG_IPV6: ipv6_enable <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // The front end takes a byte whenever the queue has room for the summary
  // that a last byte might produce.
  logic       q_full, q_empty, push, pop, accept;
  frame_sum_t push_data, head;

  assign frame.ready = !q_full;
  assign accept      = frame.valid && frame.ready;

  l4co_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .ipv6_enable (ipv6_enable),
    .accept      (accept),
    .data_byte   (frame.data_byte),
    .last_byte   (frame.last_byte),
    .outgoing    (frame.outgoing),
    .push        (push),
    .push_data   (push_data)
  );

  l4co_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  // The back end is a stall-together pipeline ending in the output register.
  l4co_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mtu_bytes   (mtu_bytes),
    .ipv6_enable (ipv6_enable),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .result      (result)
  );

endmodule

>>> hw/rtl/l4co_front.sv
// ----------------------------------------------------------------------------
// l4co_front: byte front end
// Parses headers byte by byte, accumulates the segment and address sums and
// emits one frame summary on the last byte.
// ----------------------------------------------------------------------------
module l4co_front
  import l4co_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       ipv6_enable,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       outgoing,
  output logic       push,
  output frame_sum_t push_data
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic             is6, is6_next;
  logic [7:0]       type_high, type_high_next;
  logic [3:0]       hw, hw_next;
  logic [15:0]      lenf, lenf_next;
  logic [7:0]       proto, proto_next;
  logic [7:0]       icmp6, icmp6_next;
  logic [15:0]      rc0, rc0_next, rc1, rc1_next, rc2, rc2_next;
  logic [31:0]      asum, asum_next, psum, psum_next;
  logic             dir, dir_next;

  logic [LEN_W-1:0] pe, k, start;
  logic [6:0]       hdr;
  logic [15:0]      wp;
  logic             region;

  always_comb begin
    pos_next = pos; is6_next = is6; type_high_next = type_high; hw_next = hw;
    lenf_next = lenf; proto_next = proto; icmp6_next = icmp6;
    rc0_next = rc0; rc1_next = rc1; rc2_next = rc2;
    asum_next = asum; psum_next = psum; dir_next = dir;
    pe     = LEN_W'(pos);
    wp     = pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
    hdr    = '0;
    start  = '0;
    k      = '0;
    region = 1'b0;
    push   = 1'b0;

    if (accept) begin
      if (pos == '0) dir_next = outgoing;
      if (pos != POS_W'(MAX_FRAME_BYTES)) begin
        if (pe == LEN_W'(12)) type_high_next = data_byte;
        if (pe == LEN_W'(13))
          is6_next = ipv6_enable && (type_high == ETYPE_V6_HI) && (data_byte == ETYPE_V6_LO);
        if (pe >= LEN_W'(14)) begin
          if (is6) begin
            if (pe == LEN_W'(18)) lenf_next[15:8] = data_byte;
            if (pe == LEN_W'(19)) lenf_next[7:0]  = data_byte;
            if (pe == LEN_W'(20)) proto_next      = data_byte;
            if (pe >= LEN_W'(22) && pe <= LEN_W'(53)) asum_next = asum + 32'(wp);
          end else begin
            if (pe == LEN_W'(14)) hw_next         = data_byte[3:0] & IHL_MASK;
            if (pe == LEN_W'(16)) lenf_next[15:8] = data_byte;
            if (pe == LEN_W'(17)) lenf_next[7:0]  = data_byte;
            if (pe == LEN_W'(23)) proto_next      = data_byte;
            if (pe >= LEN_W'(26) && pe <= LEN_W'(33)) asum_next = asum + 32'(wp);
          end
          hdr   = is6 ? 7'd40 : {1'b0, hw_next, 2'b00};
          start = LEN_W'(hdr) + LEN_W'(14);
          if (pe >= start) begin
            k = pe - start;
            if (is6) region = pe < start + LEN_W'(lenf_next);
            else region = (pe <= LEN_W'(17)) || (pe < LEN_W'(14) + LEN_W'(lenf_next));
            if (region) psum_next = psum + 32'(wp);
            if (k == LEN_W'(0)) icmp6_next = data_byte;
            if (k == LEN_W'(2))  rc0_next[15:8] = data_byte;
            if (k == LEN_W'(3))  rc0_next[7:0]  = data_byte;
            if (k == LEN_W'(6))  rc1_next[15:8] = data_byte;
            if (k == LEN_W'(7))  rc1_next[7:0]  = data_byte;
            if (k == LEN_W'(16)) rc2_next[15:8] = data_byte;
            if (k == LEN_W'(17)) rc2_next[7:0]  = data_byte;
          end
        end
        pos_next = pos + POS_W'(1);
      end
      push = last_byte;
    end

    push_data.len   = LEN_W'(pos_next);
    push_data.is6   = is6_next;
    push_data.hw    = hw_next;
    push_data.plen  = lenf_next;
    push_data.proto = proto_next;
    push_data.icmp6 = icmp6_next;
    push_data.rc0   = rc0_next;
    push_data.rc1   = rc1_next;
    push_data.rc2   = rc2_next;
    push_data.asum  = asum_next;
    push_data.psum  = psum_next;
    push_data.dir   = dir_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos <= '0; is6 <= 1'b0; type_high <= '0; hw <= '0; lenf <= '0;
      proto <= '0; icmp6 <= '0; rc0 <= '0; rc1 <= '0; rc2 <= '0;
      asum <= '0; psum <= '0; dir <= 1'b0;
    end else begin
      pos <= pos_next; is6 <= is6_next; type_high <= type_high_next;
      hw <= hw_next; lenf <= lenf_next; proto <= proto_next;
      icmp6 <= icmp6_next; rc0 <= rc0_next; rc1 <= rc1_next; rc2 <= rc2_next;
      asum <= asum_next; psum <= psum_next; dir <= dir_next;
    end
  end

endmodule

>>> hw/rtl/l4co_queue.sv
// ----------------------------------------------------------------------------
// l4co_queue: frame summary queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module l4co_queue
  import l4co_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_sum_t push_data,
  output logic       full,
  input  logic       pop,
  output frame_sum_t pop_data,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_sum_t       mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/l4co_back.sv
// ----------------------------------------------------------------------------
// l4co_back: checksum back end
// Three-stage pipeline: length and protocol checks with the pseudo-header
// add, then the one's complement fold, then the output word register.
// ----------------------------------------------------------------------------
module l4co_back
  import l4co_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [13:0] mtu_bytes,
  input  logic       ipv6_enable,
  input  logic       empty,
  input  frame_sum_t head,
  output logic       pop,
  l4co_out_if.source result
);

  typedef struct packed {
    logic        early;
    logic [2:0]  st;
    logic [13:0] off;
    logic [31:0] sum;
    logic [15:0] rc;
    logic        dir;
    logic        udp;
  } stage_t;

  typedef struct packed {
    logic        early;
    logic [2:0]  st;
    logic [13:0] off;
    logic [15:0] folded;
    logic        dir;
    logic        udp;
  } fold_t;

  logic   adv;
  logic   a_valid, b_valid;
  stage_t a, a_next;
  fold_t  b, b_next;

  logic [LEN_W-1:0] len;
  logic [6:0]       hdr;
  logic [15:0]      ulen;
  logic             underflow, udp, tcp, icmp, v6p, pseudo;
  logic [4:0]       need;
  logic [31:0]      t;
  logic [16:0]      f;
  logic [15:0]      val;

  assign adv = !result.valid || result.ready;
  assign pop = adv && !empty;

  // Stage A: checks in order, offset and the pre-subtraction sum.
  always_comb begin
    len       = head.len;
    hdr       = head.is6 ? 7'd40 : {1'b0, head.hw, 2'b00};
    underflow = !head.is6 && (head.plen < 16'(hdr));
    ulen      = head.is6 ? head.plen : (underflow ? 16'd0 : head.plen - 16'(hdr));
    udp       = head.proto == PROTO_UDP;
    tcp       = head.proto == PROTO_TCP;
    icmp      = (head.proto == PROTO_ICMP) || (head.proto == PROTO_IGMP);
    v6p       = (head.proto == PROTO_ICMP6) && ipv6_enable;
    pseudo    = udp || tcp || (v6p && head.is6);
    need      = ((head.icmp6 == ICMP6_ECHO_REQ) || (head.icmp6 == ICMP6_ECHO_REP)) ? 5'd8
                                                                                     : 5'd24;
    a_next.early = 1'b1;
    a_next.st    = ST_BADLEN;
    a_next.off   = '0;
    a_next.dir   = head.dir;
    a_next.udp   = udp;
    a_next.rc    = udp ? head.rc1 : (tcp ? head.rc2 : head.rc0);
    a_next.sum   = head.psum + (pseudo ? head.asum + 32'(ulen) + 32'(head.proto) : 32'd0);

    if (head.is6 ? (len < LEN_W'(54) || len < LEN_W'(54) + LEN_W'(head.plen))
                 : (len < LEN_W'(34) || len < LEN_W'(14) + LEN_W'(hdr) ||
                    len < LEN_W'(14) + LEN_W'(head.plen))) begin
      a_next.st = ST_BADLEN;
    end else if (!(udp || tcp || icmp || v6p)) begin
      a_next.st = ST_UNHANDLED;
    end else if (v6p && !udp && !tcp && !icmp ?
                 (len < LEN_W'(14) + LEN_W'(hdr) + LEN_W'(need)) :
                 (underflow || ulen < (tcp ? 16'd20 : 16'd8) ||
                  len < LEN_W'(14) + LEN_W'(hdr) + (tcp ? LEN_W'(20) : LEN_W'(8)))) begin
      a_next.st = ST_BADLEN;
    end else if (!head.dir && udp && head.rc1 == 16'd0) begin
      a_next.st  = ST_OK;
      a_next.off = 14'(7'd20 + hdr);
    end else if (underflow || ulen < 16'd8 ||
                 (17'(ulen) + 17'(hdr)) > 17'(mtu_bytes)) begin
      a_next.st = ST_BADLEN;
    end else begin
      a_next.early = 1'b0;
      a_next.off   = 14'(7'd14 + hdr) + (udp ? 14'd6 : (tcp ? 14'd16 : 14'd2));
    end
  end

  // Stage B: subtract the received field when generating, fold to 16 bits.
  always_comb begin
    t = a.dir ? a.sum - 32'(a.rc) : a.sum;
    f = {1'b0, t[31:16]} + {1'b0, t[15:0]};
    b_next.early  = a.early;
    b_next.st     = a.st;
    b_next.off    = a.off;
    b_next.dir    = a.dir;
    b_next.udp    = a.udp;
    b_next.folded = f[15:0] + {15'd0, f[16]};
    val           = ~b.folded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      a_valid      <= !empty;
      b_valid      <= a_valid;
      result.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a <= a_next;
      b <= b_next;
      result.checksum_offset <= b.off;
      if (b.early) begin
        result.status         <= b.st;
        result.checksum_value <= 16'd0;
      end else if (b.dir) begin
        result.status         <= ST_GEN;
        result.checksum_value <= (val == 16'd0 && b.udp) ? 16'hFFFF : val;
      end else begin
        result.status         <= (val == 16'd0) ? ST_OK : ST_MISMATCH;
        result.checksum_value <= val;
      end
    end
  end

endmodule

>>> sim/tb_l4_checksum_offload.sv
// ----------------------------------------------------------------------------
// tb_l4_checksum_offload: self-checking testbench for the checksum offload
// Feeds Ethernet frames byte by byte (directed table, then random IPv4/IPv6
// frames), predicts one result per frame and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_l4_checksum_offload;
  import l4co_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MTU;
  logic [13:0] cfg_data = '0;

  l4co_in_if  frame ();
  l4co_out_if result ();

  l4_checksum_offload dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .frame(frame.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  // One expected result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value;
    logic [13:0] offset;
  } csum_result_t;

  // Predictor copy of the registers and of the per-frame state.
  logic [13:0] mdl_mtu;
  logic        mdl_v6en;
  int unsigned f_pos;
  bit          f_is6;
  logic [7:0]  f_type_hi;
  logic [3:0]  f_ihl;
  logic [15:0] f_plen;
  logic [7:0]  f_proto;
  logic [7:0]  f_first;
  logic [15:0] f_rc [3];
  longint unsigned f_asum, f_psum;
  bit          f_dir;

  csum_result_t expected_q [$];
  int errors = 0;
  int frames_sent = 0, results_seen = 0, words_sent = 0;

  // Idling controls: percentages, and a hold-off counted by the receiver.
  int src_idle_pct = 0, snk_stall_pct = 0;
  int holdoff_cycles = 0;

  function automatic void clear_frame_state();
    f_pos = 0; f_is6 = 0; f_type_hi = 0; f_ihl = 0; f_plen = 0; f_proto = 0;
    f_first = 0; f_rc[0] = 0; f_rc[1] = 0; f_rc[2] = 0;
    f_asum = 0; f_psum = 0; f_dir = 0;
  endfunction

  function automatic int unsigned hdr_len();
    return f_is6 ? 40 : f_ihl * 4;
  endfunction

  function automatic void take_byte(int unsigned p, logic [7:0] d);
    int unsigned start, k, wp;
    bit in_reg;
    wp = p[0] ? d : (d << 8);
    if (p == 12) f_type_hi = d;
    if (p == 13) f_is6 = mdl_v6en && f_type_hi == ETYPE_V6_HI && d == ETYPE_V6_LO;
    if (p < 14) return;
    if (f_is6) begin
      if (p == 18) f_plen[15:8] = d;
      if (p == 19) f_plen[7:0] = d;
      if (p == 20) f_proto = d;
      if (p >= 22 && p <= 53) f_asum += wp;
    end else begin
      if (p == 14) f_ihl = d & IHL_MASK;
      if (p == 16) f_plen[15:8] = d;
      if (p == 17) f_plen[7:0] = d;
      if (p == 23) f_proto = d;
      if (p >= 26 && p <= 33) f_asum += wp;
    end
    start = 14 + hdr_len();
    if (p < start) return;
    k = p - start;
    in_reg = f_is6 ? (p < start + f_plen) : (p <= 17 || p < 14 + f_plen);
    if (in_reg) f_psum += wp;
    if (k == 0) f_first = d;
    if (k == 2) f_rc[0][15:8] = d;
    if (k == 3) f_rc[0][7:0] = d;
    if (k == 6) f_rc[1][15:8] = d;
    if (k == 7) f_rc[1][7:0] = d;
    if (k == 16) f_rc[2][15:8] = d;
    if (k == 17) f_rc[2][7:0] = d;
  endfunction

  // Closing decision for a frame, following the fixed order of length checks.
  function automatic csum_result_t close_frame(int unsigned len);
    csum_result_t r;
    int unsigned hdr, need, slot, ulen, min_seg;
    longint unsigned total, folded;
    logic [15:0] val;
    bit v6p, under;
    r = '0;
    hdr = hdr_len();
    min_seg = 8;
    v6p = 0;
    r.status = ST_BADLEN;
    if (f_is6) begin
      if (len < 54 || len < 54 + f_plen) return r;
    end else if (len < 34 || len < 14 + hdr || len < 14 + f_plen) return r;
    under = !f_is6 && f_plen < hdr;
    ulen = f_is6 ? f_plen : (under ? 0 : f_plen - hdr);
    if (f_proto == PROTO_UDP) slot = 1;
    else if (f_proto == PROTO_TCP) begin
      slot = 2; min_seg = 20;
    end else if (f_proto == PROTO_ICMP || f_proto == PROTO_IGMP) slot = 0;
    else if (f_proto == PROTO_ICMP6 && mdl_v6en) begin
      slot = 0; v6p = 1;
    end else begin
      r.status = ST_UNHANDLED;
      return r;
    end
    if (v6p) begin
      need = (f_first == ICMP6_ECHO_REQ || f_first == ICMP6_ECHO_REP) ? 8 : 24;
      if (len < 14 + hdr + need) return r;
    end else if (under || ulen < min_seg || len < 14 + hdr + min_seg) return r;
    r.offset = 14'(14 + hdr + (slot == 0 ? 2 : (slot == 1 ? 6 : 16)));
    if (!f_dir && f_proto == PROTO_UDP && f_rc[1] == 0) begin
      r.status = ST_OK;
      return r;
    end
    if (under || ulen < 8 || ulen + hdr > mdl_mtu) begin
      r.offset = 0;
      return r;
    end
    total = f_psum;
    if (f_proto == PROTO_UDP || f_proto == PROTO_TCP || (v6p && f_is6))
      total += f_asum + ulen + f_proto;
    if (f_dir) total -= f_rc[slot];
    folded = (total == 0) ? 0 : ((total - 1) % 64'hFFFF) + 1;
    val = ~folded[15:0];
    if (f_dir) begin
      if (val == 0 && f_proto == PROTO_UDP) val = 16'hFFFF;
      r.status = ST_GEN;
    end else r.status = (val == 0) ? ST_OK : ST_MISMATCH;
    r.value = val;
    return r;
  endfunction

  // Advances the predictor by one accepted word.
  task automatic predict_word(logic [7:0] d, logic last, logic og);
    if (f_pos == 0) f_dir = og;
    if (f_pos < MAX_FRAME_BYTES_DEF) begin
      take_byte(f_pos, d);
      f_pos++;
    end
    if (last) begin
      expected_q.push_back(close_frame(f_pos));
      clear_frame_state();
    end
  endtask

  // Sends one word, idling beforehand at random, and waits for acceptance.
  task automatic send_word(logic [7:0] d, logic last, logic og);
    while ($urandom_range(99) < src_idle_pct) begin
      frame.valid <= 1'b0;
      @(posedge clk);
    end
    frame.valid <= 1'b1;
    frame.data_byte <= d;
    frame.last_byte <= last;
    frame.outgoing <= og;
    do @(posedge clk); while (!frame.ready);
    predict_word(d, last, og);
    words_sent++;
  endtask

  // Sends a frame held in a byte queue.  The final word carries last_byte.
  task automatic send_frame(ref logic [7:0] bytes [$], input logic og);
    for (int i = 0; i < bytes.size(); i++)
      send_word(bytes[i], i == bytes.size() - 1, og);
    frames_sent++;
  endtask

  task automatic go_idle();
    frame.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // Frames always give a result; the wait below is a margin anyway.
    repeat (8) @(posedge clk);
  endtask

  // One write, then the enable is taken low again before the next, so that
  // back-to-back writes never drive the enable twice in one step.
  task automatic write_reg(logic idx, logic [13:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MTU) mdl_mtu = v;
    else mdl_v6en = v[0];
  endtask

  // Builds a well-formed frame.  Protocol, sizes and the checksum field are
  // chosen by the caller; the payload is random.  Where fix is set and the
  // field lies in the segment, it is filled in so verification succeeds.
  task automatic build_frame(ref logic [7:0] b [$], input bit v6, input logic [7:0] proto,
                             input int seg_len, input int ihl, input bit fix,
                             input int slack);
    int hdr, off, plen_f;
    longint unsigned s;
    logic [15:0] c;
    hdr = v6 ? 40 : ihl * 4;
    b = {};
    for (int i = 0; i < 14 + hdr + seg_len; i++) b.push_back($urandom_range(255));
    b[12] = v6 ? ETYPE_V6_HI : 8'h08;
    b[13] = v6 ? ETYPE_V6_LO : 8'h00;
    if (v6) begin
      plen_f = seg_len;
      b[18] = plen_f[15:8]; b[19] = plen_f[7:0]; b[20] = proto;
    end else begin
      plen_f = hdr + seg_len;
      b[14] = {4'h4, ihl[3:0]};
      b[16] = plen_f[15:8]; b[17] = plen_f[7:0]; b[23] = proto;
    end
    if (proto == PROTO_ICMP6 && seg_len > 0 && $urandom_range(1)) b[14 + hdr] = ICMP6_ECHO_REQ;
    for (int i = 0; i < slack; i++) b.push_back($urandom_range(255));
    if (!fix) return;
    off = 14 + hdr + (proto == PROTO_UDP ? 6 : (proto == PROTO_TCP ? 16 : 2));
    if (off + 1 >= 14 + hdr + seg_len) return;
    b[off] = 0; b[off + 1] = 0;
    s = 0;
    for (int i = 14 + hdr; i < 14 + hdr + seg_len; i++)
      s += ((i - 14 - hdr) % 2) ? b[i] : (b[i] << 8);
    if (proto == PROTO_UDP || proto == PROTO_TCP || (proto == PROTO_ICMP6 && v6)) begin
      s += seg_len + proto;
      for (int i = (v6 ? 22 : 26); i <= (v6 ? 53 : 33); i++)
        s += (i % 2) ? b[i] : (b[i] << 8);
    end
    while (s > 16'hFFFF) s = (s & 16'hFFFF) + (s >> 16);
    c = ~s[15:0];
    b[off] = c[15:8]; b[off + 1] = c[7:0];
  endtask

  // Results are taken at the same edge where the block sees ready.
  always @(posedge clk) begin
    csum_result_t got, exp_r;
    if (!rst && result.valid && result.ready) begin
      got = {result.status, result.checksum_value, result.checksum_offset};
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status || got.value !== exp_r.value
            || got.offset !== exp_r.offset) begin
          errors++;
          $display("%0t: mismatch expected st=%0d val=%h off=%0d actual st=%0d val=%h off=%0d",
                   $time, exp_r.status, exp_r.value, exp_r.offset,
                   got.status, got.value, got.offset);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      result.ready <= 1'b0;
    end else result.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Directed table: one row per frame.  A checked row holds the result
  // that can be read off directly; the rest go to the predictor alone.
  typedef struct {
    bit v6; logic [7:0] proto; int seg; int ihl; bit fix; int slack;
    logic og; int cut; bit chk; logic [2:0] st;
  } row_t;

  row_t dir_tab [] = '{
    '{0, PROTO_UDP,  8,   5, 1, 0, 0, 0, 0, ST_OK},
    '{0, PROTO_UDP,  30,  5, 1, 3, 0, 0, 0, ST_OK},
    '{0, PROTO_UDP,  12,  5, 0, 0, 1, 0, 0, ST_GEN},
    '{0, PROTO_TCP,  20,  5, 1, 0, 0, 0, 0, ST_OK},
    '{0, PROTO_TCP,  40,  15, 1, 0, 1, 0, 0, ST_GEN},
    '{0, PROTO_TCP,  19,  5, 1, 0, 0, 0, 1, ST_BADLEN},
    '{0, PROTO_ICMP, 8,   5, 1, 0, 0, 0, 0, ST_OK},
    '{0, PROTO_IGMP, 16,  6, 0, 0, 0, 0, 0, ST_MISMATCH},
    '{0, PROTO_ICMP6,24,  5, 0, 0, 0, 0, 0, ST_OK},
    '{0, 8'd255,     20,  5, 0, 0, 0, 0, 1, ST_UNHANDLED},
    '{0, PROTO_UDP,  8,   4, 0, 0, 0, 0, 0, ST_MISMATCH},
    '{0, PROTO_UDP,  8,   0, 0, 0, 0, 0, 1, ST_BADLEN},
    '{1, PROTO_UDP,  8,   5, 1, 0, 0, 0, 0, ST_OK},
    '{1, PROTO_TCP,  60,  5, 1, 0, 1, 0, 0, ST_GEN},
    '{1, PROTO_ICMP6,8,   5, 1, 0, 0, 0, 0, ST_OK},
    '{1, PROTO_ICMP6,24,  5, 1, 0, 1, 0, 0, ST_GEN},
    '{1, PROTO_ICMP6,8,   5, 0, 0, 0, 20, 0, ST_OK},
    '{1, PROTO_UDP,  16,  5, 1, 0, 0, 3, 1, ST_BADLEN},
    '{0, PROTO_UDP,  0,   5, 0, 0, 0, 40, 1, ST_BADLEN},
    '{0, PROTO_UDP,  0,   5, 0, 0, 0, 1, 1, ST_BADLEN},
    '{0, PROTO_UDP,  1480,5, 1, 0, 0, 0, 0, ST_OK},
    '{0, PROTO_UDP,  1481,5, 1, 0, 0, 0, 1, ST_BADLEN}
  };

  // Random frame: mostly well formed, some truncated, padded or corrupted.
  task automatic random_frame();
    logic [7:0] b [$];
    logic [7:0] protos [6] = '{PROTO_UDP, PROTO_TCP, PROTO_ICMP, PROTO_IGMP,
                               PROTO_ICMP6, 8'd0};
    logic [7:0] p;
    bit v6;
    int seg, r;
    r = $urandom_range(99);
    p = protos[$urandom_range(5)];
    if (p == 0) p = $urandom_range(255);
    v6 = $urandom_range(2) == 0;
    seg = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(8, 48);
    build_frame(b, v6, p, seg, $urandom_range(5, 15), $urandom_range(3) != 0,
                $urandom_range(3) == 0 ? $urandom_range(4) : 0);
    if (p == PROTO_UDP && $urandom_range(7) == 0 && b.size() > 62) begin
      b[14 + (v6 ? 40 : b[14][3:0] * 4) + 6] = 0;
      b[14 + (v6 ? 40 : b[14][3:0] * 4) + 7] = 0;
    end
    if (r < 8) begin
      int n;
      n = $urandom_range(1, b.size());
      while (b.size() > n) void'(b.pop_back());
    end else if (r < 16) b[$urandom_range(b.size() - 1)] ^= 8'(1 << $urandom_range(7));
    else if (r < 20) b[14] = $urandom_range(255);
    send_frame(b, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [7:0] b [$];
    csum_result_t row_exp;
    frame.valid = 1'b0;
    frame.data_byte = '0;
    frame.last_byte = 1'b0;
    frame.outgoing = 1'b0;
    result.ready = 1'b0;
    mdl_mtu = MTU_RESET;
    mdl_v6en = IPV6_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset register values.
    foreach (dir_tab[i]) begin
      build_frame(b, dir_tab[i].v6, dir_tab[i].proto, dir_tab[i].seg, dir_tab[i].ihl,
                  dir_tab[i].fix, dir_tab[i].slack);
      if (dir_tab[i].cut > 0) while (b.size() > dir_tab[i].cut) void'(b.pop_back());
      if (dir_tab[i].chk) begin
        // Only rejected frames are typed in: value and offset are zero.
        row_exp = '{dir_tab[i].st, 16'h0, 14'h0};
        send_frame(b, dir_tab[i].og);
        if (expected_q[$] !== row_exp) begin
          errors++;
          $display("%0t: table row %0d expected %h predicted %h", $time, i, row_exp,
                   expected_q[$]);
        end
      end else send_frame(b, dir_tab[i].og);
    end
    go_idle();

    // Random phases, one register setting and one idling pattern each.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MTU, 14'd9216); write_reg(REG_IPV6, 14'd1);
          src_idle_pct = 0; snk_stall_pct = 0;
        end
        1: begin
          write_reg(REG_MTU, 14'd576); write_reg(REG_IPV6, 14'd0);
          src_idle_pct = 75; snk_stall_pct = 0;
        end
        2: begin
          write_reg(REG_MTU, 14'd40); write_reg(REG_IPV6, 14'd1);
          src_idle_pct = 0; snk_stall_pct = 75;
        end
        3: begin
          write_reg(REG_MTU, 14'($urandom_range(576, 9216)));
          write_reg(REG_IPV6, 14'($urandom_range(1)));
          src_idle_pct = 21; snk_stall_pct = 21;
        end
        4: begin
          // Long receiver hold-off so the summary queue fills and stalls input.
          write_reg(REG_MTU, 14'd1500);
          src_idle_pct = 0; snk_stall_pct = 0;
          holdoff_cycles = 3000;
        end
        default: begin
          write_reg(REG_MTU, 14'h3FFF);
          src_idle_pct = 10; snk_stall_pct = 10;
        end
      endcase
      for (int n = 0; n < 5; n++) random_frame();
      while (words_sent < (ph + 1) * 1100 / 6 * 30) random_frame();
      go_idle();
    end

    // A frame longer than the byte limit, sent once.
    b = {};
    repeat (MAX_FRAME_BYTES_DEF + 20) b.push_back($urandom_range(255));
    send_frame(b, 1'b0);
    go_idle();
    repeat (10) @(posedge clk);

    $display("Covered %0d frames (%0d byte words) and %0d result words,", frames_sent,
             words_sent, results_seen);
    $display("over six register and idling settings plus a queue-filling hold-off.");
    if (errors == 0) $display("tb_l4_checksum_offload: done, clean");
    else $display("tb_l4_checksum_offload: done, errors");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #50ms;
    $display("tb_l4_checksum_offload: done, errors");
    $finish;
  end

endmodule
